/* rtl/tss_pkg.sv */
// ----------------------------------------------------------------------------
// Text scroll sequencer package
// Shared types, widths and codes of the text scroll sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Width of the shared divider operands and of its step counter.
  localparam int DIV_W   = 10;
  localparam int CNT_W   = 4;
  // Internal widths of the sequencer state.
  localparam int LINES_W = 5;
  localparam int TOP_W   = 5;
  localparam int Y_W     = 10;
  localparam int VIS_W   = 8;
  localparam int PAGE_W  = 5;
  localparam int ADDR_W  = 5;

  localparam logic [15:0] LINE_DEFAULT_DELAY = 16'd16;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_PAGE     = 2'd1,
    MODE_LINE     = 2'd2,
    MODE_LINE_ALT = 2'd3
  } scroll_mode_e;

  typedef enum logic [1:0] {
    DRAW_NONE   = 2'd0,
    DRAW_PAGE   = 2'd1,
    DRAW_SCROLL = 2'd2,
    DRAW_CLEAR  = 2'd3
  } draw_kind_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    REG_SCROLL_MODE = 3'd0,
    REG_LOOP_ENABLE = 3'd1,
    REG_LINE_COUNT  = 3'd2,
    REG_TEXT_SIZE   = 3'd3,
    REG_DELAY_MS    = 3'd4,
    REG_STEP_PX     = 3'd5,
    REG_PAUSE_MS    = 3'd6
  } reg_index_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_VIS,
    S_PAGES,
    S_LINE,
    S_LINE2,
    S_YMOD,
    S_TMOD,
    S_EMIT
  } seq_state_e;

  typedef struct packed {
    scroll_mode_e scroll_mode;
    logic         loop_enable;
    logic [4:0]   line_count;
    logic [3:0]   text_size;
    logic [15:0]  delay_ms;
    logic [5:0]   step_px;
    logic [15:0]  pause_ms;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

/* rtl/tss_if.sv */
// ----------------------------------------------------------------------------
// Text scroll sequencer channels
// Command channel and frame descriptor channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tss_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] now_ms;

  modport source (output valid, output command, output now_ms, input ready);
  modport sink   (input valid, input command, input now_ms, output ready);
endinterface

interface tss_frame_if;
  logic       valid;
  logic       ready;
  logic [1:0] draw_kind;
  logic [4:0] page_number;
  logic [3:0] top_line;
  logic [5:0] offset_px;
  logic       running;

  modport source (output valid, output draw_kind, output page_number, output top_line,
                  output offset_px, output running, input ready);
  modport sink   (input valid, input draw_kind, input page_number, input top_line,
                  input offset_px, input running, output ready);
endinterface

/* rtl/text_scroll_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Text scroll sequencer core
// Page flipping and pixel line scrolling sequencer emitting one frame beat
// per command beat, built around one shared iterative divider.
// ----------------------------------------------------------------------------
// Each division in the shared divider yields one quotient bit a cycle.
// One command is processed at a time; a new beat is taken once the previous
// result sits in the output register. Reset is asynchronous, active low, and
// needs no clearing pass.
module text_scroll_sequencer_core #(
  parameter int MAX_LINES         = 16,
  parameter int DISPLAY_HEIGHT_PX = 64,
  parameter int CHAR_HEIGHT_PX    = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tss_cmd_if.sink                    cmd_i,
  tss_frame_if.source                frame_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tss_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tss_pkg::*;

  localparam int          LINE_CAP = (MAX_LINES > 31) ? 31 : MAX_LINES;
  localparam logic [Y_W-1:0]   CHAR_H = Y_W'(CHAR_HEIGHT_PX);
  localparam logic [DIV_W-1:0] DISP_H = DIV_W'(DISPLAY_HEIGHT_PX);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  seq_state_e state_q, state_d;
  command_e   cmd_q, cmd_d;
  logic [31:0] now_q, now_d;
  draw_kind_e kind_q, kind_d;
  logic       active_q, active_d;
  logic [PAGE_W-1:0] page_now_q, page_now_d;
  logic [PAGE_W-1:0] page_total_q, page_total_d;
  logic [31:0] last_switch_q, last_switch_d;
  logic [31:0] pause_start_q, pause_start_d;
  logic       pause_pending_q, pause_pending_d;
  logic [Y_W-1:0]   y_q, y_d;
  logic [TOP_W-1:0] top_q, top_d;
  logic [15:0] step_delay_q, step_delay_d;
  logic [VIS_W-1:0] vis_q, vis_d;

  logic       out_valid_q, out_valid_d;
  draw_kind_e out_kind_q, out_kind_d;
  logic [4:0] out_page_q, out_page_d;
  logic [3:0] out_top_q, out_top_d;
  logic [5:0] out_off_q, out_off_d;
  logic       out_run_q, out_run_d;

  logic [LINES_W-1:0] lines;
  logic [3:0]   size_eff;
  logic [Y_W-1:0] lh;
  logic [5:0]   step_eff;
  logic [Y_W-1:0] ysum;
  logic [31:0]  elapsed;
  logic [31:0]  paused_for;
  logic         too_soon;
  logic         pause_done;
  logic         lines_zero;
  logic         lines_le_vis;
  logic [VIS_W-1:0] lines_minus_vis;
  logic [TOP_W-1:0] last_top;
  logic         ywrap;
  logic         stop_at_end;
  logic         loop_en;
  logic         mode_none;
  logic         mode_page;
  logic [PAGE_W:0] page_inc;
  logic         page_more;
  logic [VIS_W-1:0] vis_new;
  logic         out_free;

  tss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tss_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Geometry and timing terms derived from the live register values.
  assign lines      = (cfg.line_count > LINES_W'(LINE_CAP)) ? LINES_W'(LINE_CAP)
                                                          : cfg.line_count;
  assign size_eff   = (cfg.text_size == 4'd0) ? 4'd1 : cfg.text_size;
  assign lh         = CHAR_H * Y_W'(size_eff);
  assign step_eff   = (cfg.step_px == 6'd0) ? 6'd1 : cfg.step_px;
  assign ysum       = y_q + Y_W'(step_eff);
  assign elapsed    = now_q - last_switch_q;
  assign paused_for = now_q - pause_start_q;
  assign too_soon   = elapsed < {16'b0, step_delay_q};
  assign pause_done = (cfg.pause_ms == 16'd0) || (paused_for >= {16'b0, cfg.pause_ms});
  assign lines_zero = lines == '0;
  assign lines_le_vis    = VIS_W'(lines) <= vis_q;
  assign lines_minus_vis = VIS_W'(lines) - vis_q;
  assign last_top   = lines_le_vis ? '0 : lines_minus_vis[TOP_W-1:0];
  assign ywrap      = ysum >= lh;
  assign loop_en    = cfg.loop_enable;
  assign stop_at_end = !loop_en && (top_q == last_top) && ywrap;
  assign mode_none  = cfg.scroll_mode == MODE_NONE;
  assign mode_page  = cfg.scroll_mode == MODE_PAGE;
  assign page_inc   = {1'b0, page_now_q} + 1'b1;
  assign page_more  = page_inc < {1'b0, page_total_q};
  assign vis_new    = (div_rsp.quo == '0) ? VIS_W'(1) : div_rsp.quo[VIS_W-1:0];
  assign out_free   = !out_valid_q || frame_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (cmd_q == CMD_START) begin
          state_d = (lines_zero || mode_none) ? S_EMIT : S_VIS;
        end else if (!active_q || mode_none || too_soon || mode_page) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_VIS;
        end
      end
      S_VIS: begin
        if (div_rsp.done) state_d = (cmd_q == CMD_START) ? S_PAGES : S_LINE;
      end
      S_PAGES: begin
        if (div_rsp.done) state_d = S_EMIT;
      end
      S_LINE: begin
        if ((loop_en && lines_le_vis) || (pause_pending_q && !pause_done)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_LINE2;
        end
      end
      S_LINE2: begin
        if ((!loop_en && lines_le_vis) || stop_at_end || !ywrap) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_YMOD;
        end
      end
      S_YMOD: begin
        if (div_rsp.done) state_d = (loop_en && !lines_zero) ? S_TMOD : S_EMIT;
      end
      S_TMOD: begin
        if (div_rsp.done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath updates and divider requests.
  always_comb begin
    cmd_d           = cmd_q;
    now_d           = now_q;
    kind_d          = kind_q;
    active_d        = active_q;
    page_now_d      = page_now_q;
    page_total_d    = page_total_q;
    last_switch_d   = last_switch_q;
    pause_start_d   = pause_start_q;
    pause_pending_d = pause_pending_q;
    y_d             = y_q;
    top_d           = top_q;
    step_delay_d    = step_delay_q;
    vis_d           = vis_q;
    div_req         = '0;
    out_valid_d     = out_valid_q && !frame_o.ready;
    out_kind_d      = out_kind_q;
    out_page_d      = out_page_q;
    out_top_d       = out_top_q;
    out_off_d       = out_off_q;
    out_run_d       = out_run_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d = command_e'(cmd_i.command);
          now_d = cmd_i.now_ms;
        end
      end
      S_DISPATCH: begin
        if (cmd_q == CMD_START) begin
          if (lines_zero) begin
            active_d = 1'b0;
            kind_d   = DRAW_CLEAR;
          end else if (mode_none) begin
            active_d   = 1'b0;
            page_now_d = '0;
            kind_d     = DRAW_PAGE;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = DISP_H;
            div_req.den   = lh;
          end
        end else begin
          kind_d = DRAW_NONE;
          if (active_q && !mode_none && !too_soon) begin
            last_switch_d = now_q;
            if (mode_page) begin
              if (page_more) begin
                page_now_d = page_inc[PAGE_W-1:0];
                kind_d     = DRAW_PAGE;
              end else if (loop_en) begin
                page_now_d = '0;
                kind_d     = DRAW_PAGE;
              end else begin
                active_d = 1'b0;
              end
            end else begin
              div_req.start = 1'b1;
              div_req.num   = DISP_H;
              div_req.den   = lh;
            end
          end
        end
      end
      S_VIS: begin
        if (div_rsp.done) begin
          vis_d = vis_new;
          // A start goes on to the page count, the ceiling of lines over visible lines.
          if (cmd_q == CMD_START) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(lines) + DIV_W'(vis_new) - 1'b1;
            div_req.den   = DIV_W'(vis_new);
          end
        end
      end
      S_PAGES: begin
        if (div_rsp.done) begin
          page_total_d = div_rsp.quo[PAGE_W-1:0];
          if (mode_page) begin
            step_delay_d = (cfg.delay_ms == 16'd0) ? 16'd1 : cfg.delay_ms;
          end else begin
            step_delay_d    = (cfg.delay_ms == 16'd0) ? LINE_DEFAULT_DELAY : cfg.delay_ms;
            y_d             = '0;
            top_d           = '0;
            pause_pending_d = 1'b0;
          end
          page_now_d    = '0;
          active_d      = !((div_rsp.quo == DIV_W'(1)) && !loop_en);
          last_switch_d = now_q;
          kind_d        = DRAW_PAGE;
        end
      end
      S_LINE: begin
        kind_d = DRAW_SCROLL;
        if (loop_en && lines_le_vis) begin
          y_d      = '0;
          top_d    = '0;
          active_d = 1'b0;
        end else if (pause_pending_q && pause_done) begin
          pause_pending_d = 1'b0;
        end
      end
      S_LINE2: begin
        if (!loop_en && lines_le_vis) begin
          active_d = 1'b0;
        end else if (stop_at_end) begin
          y_d      = '0;
          active_d = 1'b0;
        end else if (!ywrap) begin
          y_d = ysum;
        end else begin
          // Snap to the next line and keep the remainder of the offset.
          div_req.start = 1'b1;
          div_req.num   = ysum;
          div_req.den   = lh;
        end
      end
      S_YMOD: begin
        if (div_rsp.done) begin
          y_d = div_rsp.rem;
          if (loop_en) begin
            if (lines_zero) begin
              if (cfg.pause_ms != 16'd0) begin
                pause_pending_d = 1'b1;
                pause_start_d   = now_q;
              end
            end else begin
              div_req.start = 1'b1;
              div_req.num   = DIV_W'(top_q) + 1'b1;
              div_req.den   = DIV_W'(lines);
            end
          end else if (top_q < last_top) begin
            top_d = top_q + 1'b1;
            if (cfg.pause_ms != 16'd0) begin
              pause_pending_d = 1'b1;
              pause_start_d   = now_q;
            end
          end else begin
            y_d      = '0;
            active_d = 1'b0;
          end
        end
      end
      S_TMOD: begin
        if (div_rsp.done) begin
          top_d = div_rsp.rem[TOP_W-1:0];
          if (cfg.pause_ms != 16'd0) begin
            pause_pending_d = 1'b1;
            pause_start_d   = now_q;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_page_d  = (kind_q == DRAW_PAGE) ? page_now_q : '0;
          out_top_d   = (kind_q == DRAW_SCROLL) ? top_q[3:0] : '0;
          if (kind_q != DRAW_SCROLL) begin
            out_off_d = '0;
          end else begin
            out_off_d = (y_q > Y_W'(63)) ? 6'd63 : y_q[5:0];
          end
          out_run_d = active_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      active_q        <= 1'b0;
      page_now_q      <= '0;
      page_total_q    <= PAGE_W'(1);
      last_switch_q   <= '0;
      pause_start_q   <= '0;
      pause_pending_q <= 1'b0;
      y_q             <= '0;
      top_q           <= '0;
      step_delay_q    <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      active_q        <= active_d;
      page_now_q      <= page_now_d;
      page_total_q    <= page_total_d;
      last_switch_q   <= last_switch_d;
      pause_start_q   <= pause_start_d;
      pause_pending_q <= pause_pending_d;
      y_q             <= y_d;
      top_q           <= top_d;
      step_delay_q    <= step_delay_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    now_q      <= now_d;
    kind_q     <= kind_d;
    vis_q      <= vis_d;
    out_kind_q <= out_kind_d;
    out_page_q <= out_page_d;
    out_top_q  <= out_top_d;
    out_off_q  <= out_off_d;
    out_run_q  <= out_run_d;
  end

  assign cmd_i.ready         = state_q == S_IDLE;
  assign frame_o.valid       = out_valid_q;
  assign frame_o.draw_kind   = out_kind_q;
  assign frame_o.page_number = out_page_q;
  assign frame_o.top_line    = out_top_q;
  assign frame_o.offset_px   = out_off_q;
  assign frame_o.running     = out_run_q;

  // The shared divider is only started when it is idle.
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A command beat is never taken in the cycle right after another.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command taken while previous one in progress");

  // The current page always lies inside the page count.
  a_page_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (page_now_q == '0) || (page_now_q < page_total_q))
    else $error("page index beyond page count");

endmodule

/* rtl/tss_regs.sv */
// ----------------------------------------------------------------------------
// Text scroll sequencer configuration registers
// APB register file holding the scroll mode, timing and geometry settings.
// ----------------------------------------------------------------------------
module tss_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tss_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tss_pkg::cfg_t              cfg_o
);
  import tss_pkg::*;

  cfg_t       cfg_q;
  reg_index_e reg_idx;
  logic       wr_en;

  assign reg_idx = reg_index_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scroll_mode <= MODE_NONE;
      cfg_q.loop_enable <= 1'b1;
      cfg_q.line_count  <= '0;
      cfg_q.text_size   <= 4'd1;
      cfg_q.delay_ms    <= '0;
      cfg_q.step_px     <= 6'd1;
      cfg_q.pause_ms    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCROLL_MODE: cfg_q.scroll_mode <= scroll_mode_e'(pwdata[1:0]);
        REG_LOOP_ENABLE: cfg_q.loop_enable <= pwdata[0];
        REG_LINE_COUNT:  cfg_q.line_count  <= pwdata[4:0];
        REG_TEXT_SIZE:   cfg_q.text_size   <= pwdata[3:0];
        REG_DELAY_MS:    cfg_q.delay_ms    <= pwdata[15:0];
        REG_STEP_PX:     cfg_q.step_px     <= pwdata[5:0];
        REG_PAUSE_MS:    cfg_q.pause_ms    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCROLL_MODE: prdata = {30'b0, cfg_q.scroll_mode};
      REG_LOOP_ENABLE: prdata = {31'b0, cfg_q.loop_enable};
      REG_LINE_COUNT:  prdata = {27'b0, cfg_q.line_count};
      REG_TEXT_SIZE:   prdata = {28'b0, cfg_q.text_size};
      REG_DELAY_MS:    prdata = {16'b0, cfg_q.delay_ms};
      REG_STEP_PX:     prdata = {26'b0, cfg_q.step_px};
      REG_PAUSE_MS:    prdata = {16'b0, cfg_q.pause_ms};
      default:         prdata = '0;
    endcase
  end

endmodule

/* rtl/tss_divider.sv */
// ----------------------------------------------------------------------------
// Text scroll sequencer divider
// Restoring divider shared by all quotient and remainder steps, one bit a cycle.
// ----------------------------------------------------------------------------
module tss_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tss_pkg::div_req_t req_i,
  output tss_pkg::div_rsp_t rsp_o
);
  import tss_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  // The dividend shifts out of quo_q from the top while quotient bits enter at the bottom.
  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
